// File: rtl/pct_pkg.sv
// shared types, codes and sizes of the peer connection table
`default_nettype none

package pct_pkg;

   // table size and derived widths
   localparam int MAX_NODES    = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int IDX_W        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NODE_W       = $clog2(MAX_NODES + 1);
   localparam int CNT_W        = (NODE_W > 5) ? NODE_W : 5;
   localparam int RES_W        = $clog2(RESULT_LIMIT + 1);
   localparam int SLOT_W       = 4;
   localparam int ADDR_W       = 48;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL_ID   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT    = 2'd2;

   // register reset values
   localparam logic [31:0] PROTOCOL_ID_RST   = 32'd0;
   localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd1000;
   localparam logic [4:0]  NODE_COUNT_RST    = 5'd16;

   // slot states
   localparam logic [1:0] ST_DISC       = 2'd0;
   localparam logic [1:0] ST_CONNECTING = 2'd1;
   localparam logic [1:0] ST_CONNECTED  = 2'd2;

   // packet types
   localparam logic [7:0] PT_CONNECT   = 8'd0;
   localparam logic [7:0] PT_KEEPALIVE = 8'd1;

   // result events
   localparam logic [2:0] EV_DROPPED   = 3'd0;
   localparam logic [2:0] EV_RESERVED  = 3'd1;
   localparam logic [2:0] EV_FULL      = 3'd2;
   localparam logic [2:0] EV_CONN_REF  = 3'd3;
   localparam logic [2:0] EV_COMPLETED = 3'd4;
   localparam logic [2:0] EV_KA_REF    = 3'd5;
   localparam logic [2:0] EV_NO_CHANGE = 3'd6;
   localparam logic [2:0] EV_TIMED_OUT = 3'd7;

   // input word
   typedef struct packed {
      logic        mode;
      logic [31:0] header_word;
      logic [7:0]  packet_type;
      logic [31:0] sender_ip;
      logic [15:0] sender_port;
      logic [15:0] elapsed;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [2:0]        event_res;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } rsp_word_type;

   // slot number as reported in the result
   function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, idx};
      return ext[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/peer_connection_table.sv
// peer connection table: slot store with a one-slot-per-cycle walk sequencer
//
//  port group | direction | flow control     | carries
//  req_*      | in        | req_valid/stall  | packet or tick word (req_word_type)
//  rsp_*      | out       | rsp_valid/stall  | result word (rsp_word_type)
//  csr_*      | in        | csr_write_en     | register index and write data
//
// An item passes through the accept cycle, a walk over n = min(node_count, MAX_NODES)
// slots, one per cycle, then a final state; a malformed packet or n = 0 has no walk.
// A tick's walk stalls while a freed slot's word cannot be loaded, and the final
// cycle of any item waits while the output register holds a stalled word.
// Reset clears slot states, reserved flags and counts, not addresses;
// one item at a time, and a finished word may wait while the next item is taken.
`default_nettype none

module peer_connection_table (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire pct_pkg::req_word_type   req_word,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output pct_pkg::rsp_word_type        rsp_word,
   input  wire                          csr_write_en,
   input  wire [pct_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [pct_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pct_pkg::*;

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_PKT  = 3'd2;
   localparam logic [2:0] S_TICK = 3'd3;
   localparam logic [2:0] S_TEND = 3'd4;

   // configuration registers
   logic [31:0] protocol_id_ff;
   logic [15:0] timeout_limit_ff;
   logic [4:0]  node_count_ff;

   // slot table
   logic [1:0]        slot_state_ff    [MAX_NODES];
   logic              slot_reserved_ff [MAX_NODES];
   logic [15:0]       slot_age_ff      [MAX_NODES];
   logic [ADDR_W-1:0] slot_address_ff  [MAX_NODES];

   // table write port
   logic             tbl_we;
   logic             addr_we;
   logic [IDX_W-1:0] tbl_idx;
   logic [1:0]       slot_state_in;
   logic             slot_reserved_in;
   logic [15:0]      slot_age_in;

   // sequencer and item registers
   logic [2:0]       seq_ff, seq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   req_word_type     item_ff, item_in;
   logic             bad_ff, bad_in;
   logic             known_vld_ff, known_vld_in;
   logic [IDX_W-1:0] known_idx_ff, known_idx_in;
   logic             known_conn_ff, known_conn_in;
   logic             free_vld_ff, free_vld_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [RES_W-1:0] res_cnt_ff, res_cnt_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         push;
   rsp_word_type push_word;

   // walk datapath
   logic [CNT_W-1:0]  used;
   logic [CNT_W-1:0]  used_m1;
   logic              walk_last;
   logic [IDX_W-1:0]  cur;
   logic [1:0]        cur_state;
   logic              cur_active;
   logic              addr_hit;
   logic [16:0]       age_sum;
   logic [15:0]       age_sat;
   logic              expired;
   logic              record;
   logic              out_free;
   logic              req_take;
   logic              pkt_bad;
   logic [ADDR_W-1:0] item_addr;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_id_ff   <= PROTOCOL_ID_RST;
         timeout_limit_ff <= TIMEOUT_LIMIT_RST;
         node_count_ff    <= NODE_COUNT_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PROTOCOL_ID:   protocol_id_ff   <= csr_wdata[31:0];
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata[15:0];
            CSR_NODE_COUNT:    node_count_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // slots in use
   always_comb begin
      if (CNT_W'(node_count_ff) > CNT_W'(MAX_NODES)) begin
         used = CNT_W'(MAX_NODES);
      end else begin
         used = CNT_W'(node_count_ff);
      end
      used_m1   = used - CNT_W'(1);
      walk_last = (cnt_ff == used_m1);
   end

   // one slot examined per cycle, unless a tick's walk is stalled
   assign item_addr  = {item_ff.sender_ip, item_ff.sender_port};
   assign cur        = cnt_ff[IDX_W-1:0];
   assign cur_state  = slot_state_ff[cur];
   assign cur_active = (cur_state != ST_DISC);
   assign addr_hit   = cur_active && (slot_address_ff[cur] == item_addr);
   assign age_sum    = {1'b0, slot_age_ff[cur]} + {1'b0, item_ff.elapsed};
   assign age_sat    = age_sum[16] ? 16'hFFFF : age_sum[15:0];
   assign expired    = (age_sat > timeout_limit_ff) && !slot_reserved_ff[cur];
   assign record     = cur_active && expired && (res_cnt_ff < RES_W'(RESULT_LIMIT));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (seq_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign pkt_bad   = (req_word.header_word != protocol_id_ff) ||
                      (req_word.packet_type > PT_KEEPALIVE);

   // sequencer
   always_comb begin
      seq_in        = seq_ff;
      cnt_in        = cnt_ff;
      item_in       = item_ff;
      bad_in        = bad_ff;
      known_vld_in  = known_vld_ff;
      known_idx_in  = known_idx_ff;
      known_conn_in = known_conn_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      res_cnt_in    = res_cnt_ff;

      tbl_we           = 1'b0;
      addr_we          = 1'b0;
      tbl_idx          = cur;
      slot_state_in    = cur_state;
      slot_reserved_in = slot_reserved_ff[cur];
      slot_age_in      = age_sat;

      push      = 1'b0;
      push_word = '{event_res: EV_NO_CHANGE, slot: '0, last: 1'b1};

      case (seq_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in      = req_word;
               bad_in       = pkt_bad;
               cnt_in       = '0;
               known_vld_in = 1'b0;
               free_vld_in  = 1'b0;
               pend_vld_in  = 1'b0;
               res_cnt_in   = '0;
               if (req_word.mode) begin
                  seq_in = (used == '0) ? S_TEND : S_TICK;
               end else if (pkt_bad || (used == '0)) begin
                  seq_in = S_PKT;
               end else begin
                  seq_in = S_SCAN;
               end
            end
         end

         // lookup of known sender and first free slot
         S_SCAN: begin
            if (addr_hit && !known_vld_ff) begin
               known_vld_in  = 1'b1;
               known_idx_in  = cur;
               known_conn_in = (cur_state == ST_CONNECTING);
            end
            if (!cur_active && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = cur;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (walk_last) begin
               seq_in = S_PKT;
            end
         end

         // apply the packet and report
         S_PKT: begin
            if (out_free) begin
               push   = 1'b1;
               seq_in = S_IDLE;
               if (bad_ff) begin
                  push_word = '{event_res: EV_DROPPED, slot: '0, last: 1'b1};
               end else if (item_ff.packet_type == PT_CONNECT) begin
                  if (known_vld_ff) begin
                     if (known_conn_ff) begin
                        tbl_we           = 1'b1;
                        tbl_idx          = known_idx_ff;
                        slot_state_in    = ST_CONNECTING;
                        slot_reserved_in = 1'b1;
                        slot_age_in      = '0;
                        push_word = '{event_res: EV_CONN_REF,
                                      slot: slot_field(known_idx_ff), last: 1'b1};
                     end else begin
                        push_word = '{event_res: EV_NO_CHANGE,
                                      slot: slot_field(known_idx_ff), last: 1'b1};
                     end
                  end else if (free_vld_ff) begin
                     tbl_we           = 1'b1;
                     addr_we          = 1'b1;
                     tbl_idx          = free_idx_ff;
                     slot_state_in    = ST_CONNECTING;
                     slot_reserved_in = 1'b1;
                     slot_age_in      = '0;
                     push_word = '{event_res: EV_RESERVED,
                                   slot: slot_field(free_idx_ff), last: 1'b1};
                  end else begin
                     push_word = '{event_res: EV_FULL, slot: '0, last: 1'b1};
                  end
               end else begin
                  if (known_vld_ff) begin
                     tbl_we           = 1'b1;
                     tbl_idx          = known_idx_ff;
                     slot_state_in    = ST_CONNECTED;
                     slot_reserved_in = 1'b0;
                     slot_age_in      = '0;
                     push_word = '{event_res: EV_KA_REF,
                                   slot: slot_field(known_idx_ff), last: 1'b1};
                     if (known_conn_ff) begin
                        push_word.event_res = EV_COMPLETED;
                     end
                  end else begin
                     push_word = '{event_res: EV_NO_CHANGE, slot: '0, last: 1'b1};
                  end
               end
            end
         end

         // age one slot per cycle while not stalled, free the expired ones
         S_TICK: begin
            if (!(record && pend_vld_ff) || out_free) begin
               if (cur_active) begin
                  tbl_we = 1'b1;
                  if (expired) begin
                     slot_state_in    = ST_DISC;
                     slot_reserved_in = 1'b0;
                     slot_age_in      = '0;
                  end
               end
               if (record) begin
                  if (pend_vld_ff) begin
                     push      = 1'b1;
                     push_word = '{event_res: EV_TIMED_OUT,
                                   slot: slot_field(pend_idx_ff), last: 1'b0};
                  end
                  pend_vld_in = 1'b1;
                  pend_idx_in = cur;
                  res_cnt_in  = res_cnt_ff + RES_W'(1);
               end
               cnt_in = cnt_ff + CNT_W'(1);
               if (walk_last) begin
                  seq_in = S_TEND;
               end
            end
         end

         // final word of a tick
         S_TEND: begin
            if (out_free) begin
               push        = 1'b1;
               pend_vld_in = 1'b0;
               seq_in      = S_IDLE;
               if (pend_vld_ff) begin
                  push_word = '{event_res: EV_TIMED_OUT,
                                slot: slot_field(pend_idx_ff), last: 1'b1};
               end
            end
         end

         default: begin
            seq_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = push_word;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         known_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         res_cnt_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         known_vld_ff <= known_vld_in;
         free_vld_ff  <= free_vld_in;
         pend_vld_ff  <= pend_vld_in;
         res_cnt_ff   <= res_cnt_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      bad_ff        <= bad_in;
      known_idx_ff  <= known_idx_in;
      known_conn_ff <= known_conn_in;
      free_idx_ff   <= free_idx_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // slot state, flags and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            slot_state_ff[i]    <= ST_DISC;
            slot_reserved_ff[i] <= 1'b0;
            slot_age_ff[i]      <= '0;
         end
      end else if (tbl_we) begin
         slot_state_ff[tbl_idx]    <= slot_state_in;
         slot_reserved_ff[tbl_idx] <= slot_reserved_in;
         slot_age_ff[tbl_idx]      <= slot_age_in;
      end
   end

   // sender addresses
   always_ff @(posedge clock) begin
      if (addr_we) begin
         slot_address_ff[tbl_idx] <= item_addr;
      end
   end

`ifndef SYNTHESIS
   // a word is never loaded over one that is still held
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_valid_ff) |-> !rsp_stall)
      else $error("result word overwritten while stalled");

   // reported count never passes the limit
   a_res_limit: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= RES_W'(RESULT_LIMIT))
      else $error("result count above limit");

   // a reservation only takes a free slot
   a_reserve_free: assert property (@(posedge clock) disable iff (reset)
      addr_we |-> (slot_state_ff[tbl_idx] == ST_DISC))
      else $error("reservation of an active slot");

   // a found sender is still active when the packet is applied
   a_known_active: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == S_PKT && known_vld_ff) |-> (slot_state_ff[known_idx_ff] != ST_DISC))
      else $error("known slot not active");

   // finishing an item leaves a final word in the output register
   a_final_word: assert property (@(posedge clock) disable iff (reset)
      ((seq_ff == S_PKT || seq_ff == S_TEND) && out_free) |=>
         (rsp_valid_ff && rsp_word_ff.last && seq_ff == S_IDLE))
      else $error("item finished without final word");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the peer connection table
`timescale 1ns / 100ps

module tb_top;
   import pct_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = MAX_NODES + 4;

   // expected behavior of the slot table and the queue of awaited result words
   class peer_table_scoreboard;
      localparam int MAX_REPORTS = 10;

      logic [31:0]  protocol_id;
      logic [15:0]  timeout_limit;
      logic [4:0]   node_count;
      logic [1:0]   slot_st   [MAX_NODES];
      bit           slot_rsv  [MAX_NODES];
      logic [15:0]  slot_cnt  [MAX_NODES];
      logic [47:0]  slot_peer [MAX_NODES];
      rsp_word_type awaited_events [$];
      int           failures;

      function new();
         protocol_id   = PROTOCOL_ID_RST;
         timeout_limit = TIMEOUT_LIMIT_RST;
         node_count    = NODE_COUNT_RST;
         failures      = 0;
         foreach (slot_st[i]) begin
            slot_st[i]   = ST_DISC;
            slot_rsv[i]  = 1'b0;
            slot_cnt[i]  = '0;
            slot_peer[i] = '0;
         end
      endfunction

      function void set_config(input logic [31:0] proto, input logic [15:0] lim,
                               input logic [4:0] count);
         protocol_id   = proto;
         timeout_limit = lim;
         node_count    = count;
      endfunction

      function int slots_in_use();
         return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
      endfunction

      function int outstanding();
         return awaited_events.size();
      endfunction

      function void await_event(input logic [2:0] ev, input int idx, input logic last);
         rsp_word_type e;
         e.event_res = ev;
         e.slot      = SLOT_W'(idx);
         e.last      = last;
         awaited_events.push_back(e);
      endfunction

      // update the table for one accepted request word and queue its results
      function void note_request(input req_word_type w);
         int          n;
         int          hit;
         int          free_idx;
         int          freed_slots [$];
         logic [47:0] peer;
         logic [16:0] sum;
         n = slots_in_use();
         if (w.mode) begin
            // tick: age active slots, free unreserved ones past the limit
            for (int i = 0; i < n; i++) begin
               if (slot_st[i] != ST_DISC) begin
                  sum = {1'b0, slot_cnt[i]} + {1'b0, w.elapsed};
                  if (sum > 17'h0FFFF) sum = 17'h0FFFF;
                  slot_cnt[i] = sum[15:0];
                  if (sum > {1'b0, timeout_limit} && !slot_rsv[i]) begin
                     slot_st[i]  = ST_DISC;
                     slot_rsv[i] = 1'b0;
                     slot_cnt[i] = '0;
                     if (freed_slots.size() < RESULT_LIMIT) freed_slots.push_back(i);
                  end
               end
            end
            if (freed_slots.size() == 0) await_event(EV_NO_CHANGE, 0, 1'b1);
            foreach (freed_slots[j])
               await_event(EV_TIMED_OUT, freed_slots[j], j == freed_slots.size() - 1);
            return;
         end
         // malformed packet
         if (w.header_word != protocol_id || w.packet_type > PT_KEEPALIVE) begin
            await_event(EV_DROPPED, 0, 1'b1);
            return;
         end
         // lowest active slot holding this sender
         peer = {w.sender_ip, w.sender_port};
         hit  = -1;
         for (int i = n - 1; i >= 0; i--)
            if (slot_st[i] != ST_DISC && slot_peer[i] == peer) hit = i;
         if (w.packet_type == PT_CONNECT) begin
            if (hit >= 0) begin
               if (slot_st[hit] == ST_CONNECTING) begin
                  slot_cnt[hit] = '0;
                  await_event(EV_CONN_REF, hit, 1'b1);
               end else begin
                  await_event(EV_NO_CHANGE, hit, 1'b1);
               end
            end else begin
               free_idx = -1;
               for (int i = n - 1; i >= 0; i--)
                  if (slot_st[i] == ST_DISC) free_idx = i;
               if (free_idx < 0) begin
                  await_event(EV_FULL, 0, 1'b1);
               end else begin
                  slot_st[free_idx]   = ST_CONNECTING;
                  slot_rsv[free_idx]  = 1'b1;
                  slot_cnt[free_idx]  = '0;
                  slot_peer[free_idx] = peer;
                  await_event(EV_RESERVED, free_idx, 1'b1);
               end
            end
         end else if (hit >= 0) begin
            // keepalive from a known sender
            if (slot_st[hit] == ST_CONNECTING) begin
               slot_st[hit]  = ST_CONNECTED;
               slot_rsv[hit] = 1'b0;
               await_event(EV_COMPLETED, hit, 1'b1);
            end else begin
               await_event(EV_KA_REF, hit, 1'b1);
            end
            slot_cnt[hit] = '0;
         end else begin
            await_event(EV_NO_CHANGE, 0, 1'b1);
         end
      endfunction

      // compare one accepted result word with the oldest awaited one
      function void check_result(input rsp_word_type got);
         rsp_word_type want;
         if (awaited_events.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("unexpected result word: event %0d slot %0d last %0b",
                        got.event_res, got.slot, got.last);
            failures++;
            return;
         end
         want = awaited_events.pop_front();
         if (got.event_res !== want.event_res || got.slot !== want.slot ||
             got.last !== want.last) begin
            if (failures < MAX_REPORTS)
               $display("result mismatch: expected event %0d slot %0d last %0b, got event %0d slot %0d last %0b",
                        want.event_res, want.slot, want.last,
                        got.event_res, got.slot, got.last);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   req_word_type          req_word     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   peer_table_scoreboard sb = new();

   int stall_left  = 0;
   int stall_pick;
   int burst_left  = 0;
   int quiet_cycles;

   peer_connection_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side back-pressure: free runs, short stalls and a few long ones
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 45) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(1, 12);
         end else if (stall_pick < 55) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(20, 60);
         end else if (stall_pick < 92) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(8, 30);
         end
      end
      stall_left = stall_left - 1;
   end

   // check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
   end

   // watchdog on cycles without any handshake
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // idle cycles before the next request word, with bursts of none
   function automatic int next_gap();
      int p;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      p = $urandom_range(0, 99);
      if (p < 8) begin
         burst_left = $urandom_range(5, 20);
         return 0;
      end
      if (p < 45) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 96) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic req_word_type packet_word(input logic [31:0] hdr, input logic [7:0] kind,
                                                input logic [31:0] ip, input logic [15:0] port);
      req_word_type w;
      w.mode        = 1'b0;
      w.header_word = hdr;
      w.packet_type = kind;
      w.sender_ip   = ip;
      w.sender_port = port;
      w.elapsed     = 16'($urandom);
      return w;
   endfunction

   function automatic req_word_type tick_word(input logic [15:0] span);
      req_word_type w;
      w.mode        = 1'b1;
      w.header_word = $urandom;
      w.packet_type = 8'($urandom);
      w.sender_ip   = $urandom;
      w.sender_port = 16'($urandom);
      w.elapsed     = span;
      return w;
   endfunction

   // present one request word and hold it until taken
   task automatic send_item(input req_word_type w);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(w);
   endtask

   // write all three registers back to back
   task automatic configure(input logic [31:0] proto, input logic [15:0] lim,
                            input logic [4:0] count);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PROTOCOL_ID;
      csr_wdata    <= proto;
      @(posedge clock);
      csr_index    <= CSR_TIMEOUT_LIMIT;
      csr_wdata    <= {16'b0, lim};
      @(posedge clock);
      csr_index    <= CSR_NODE_COUNT;
      csr_wdata    <= {27'b0, count};
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_config(proto, lim, count);
   endtask

   // stop sending, drain all awaited results, let the walk settle
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // two slots, limit 100: fill, full, refresh, complete, drop, age and free
   task automatic run_directed();
      logic [31:0] p;
      p = sb.protocol_id;
      send_item(packet_word(p, PT_CONNECT, 32'h0000_0000, 16'h0000));
      send_item(packet_word(p, PT_CONNECT, 32'hFFFF_FFFF, 16'hFFFF));
      send_item(packet_word(p, PT_CONNECT, 32'h0000_0000, 16'hFFFF));
      send_item(packet_word(p, PT_CONNECT, 32'h0000_0000, 16'h0000));
      send_item(packet_word(p, PT_KEEPALIVE, 32'h0000_0000, 16'hFFFF));
      send_item(packet_word(p, PT_KEEPALIVE, 32'h0000_0000, 16'h0000));
      send_item(packet_word(p, PT_KEEPALIVE, 32'h0000_0000, 16'h0000));
      send_item(packet_word(p, PT_CONNECT, 32'h0000_0000, 16'h0000));
      send_item(packet_word(32'h0000_0000, PT_CONNECT, 32'h0000_0000, 16'h0000));
      send_item(packet_word(p, 8'd2, 32'h0000_0000, 16'h0000));
      send_item(packet_word(p, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
      send_item(packet_word(p, 8'h80, 32'h0000_0000, 16'h0000));
      send_item(tick_word(16'h0000));
      send_item(tick_word(16'hFFFF));
      send_item(tick_word(16'hFFFF));
      send_item(packet_word(p, PT_KEEPALIVE, 32'hFFFF_FFFF, 16'hFFFF));
      send_item(tick_word(16'd101));
      send_item(packet_word(p, PT_CONNECT, 32'hFFFF_FFFF, 16'h0000));
      send_item(packet_word(p, PT_CONNECT, 32'h0000_0000, 16'hFFFF));
      send_item(packet_word(p, PT_KEEPALIVE, 32'hFFFF_FFFF, 16'h0000));
      send_item(packet_word(p, PT_KEEPALIVE, 32'h0000_0000, 16'hFFFF));
      send_item(tick_word(16'd100));
      send_item(tick_word(16'd1));
      send_item(packet_word(p, PT_KEEPALIVE, 32'hFFFF_FFFF, 16'h0000));
   endtask

   // random traffic from a small pool of senders so that slots get reused
   task automatic run_random(input int item_total, input int pool_size);
      logic [47:0]  pool [24];
      logic [47:0]  peer;
      req_word_type w;
      int           pick;
      int           lim;
      int           hi;
      for (int i = 0; i < pool_size; i++) begin
         pool[i] = {$urandom, 16'($urandom)};
         // near twins: same ip or same port as the previous sender
         if (i > 0 && $urandom_range(0, 9) < 3) pool[i][47:16] = pool[i-1][47:16];
         else if (i > 0 && $urandom_range(0, 9) < 2) pool[i][15:0] = pool[i-1][15:0];
      end
      for (int k = 0; k < item_total; k++) begin
         pick = $urandom_range(0, 99);
         lim  = sb.timeout_limit;
         if (pick < 20) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               w = tick_word(16'($urandom_range(0, lim / 4 + 1)));
            end else if (pick < 85) begin
               hi = (lim + 2 > 65535) ? 65535 : lim + 2;
               w  = tick_word(16'($urandom_range(lim / 2, hi)));
            end else begin
               w = tick_word(16'($urandom_range(0, 65535)));
            end
         end else begin
            peer = pool[$urandom_range(0, pool_size - 1)];
            pick = $urandom_range(0, 99);
            w = packet_word(sb.protocol_id, (pick < 45) ? PT_CONNECT : PT_KEEPALIVE,
                            peer[47:16], peer[15:0]);
            if (pick >= 92) w.packet_type = 8'($urandom_range(2, 255));
            if ($urandom_range(0, 99) < 6) w.header_word = $urandom;
         end
         send_item(w);
      end
   endtask

   // main sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(32'hFFFF_FFFF, 16'd100, 5'd2);
      run_directed();
      finish_phase();

      configure(32'h0000_0000, 16'd0, 5'd16);
      run_random(40, 20);
      finish_phase();

      configure(32'hFFFF_FFFF, 16'hFFFF, 5'd1);
      run_random(30, 3);
      finish_phase();

      configure($urandom, 16'($urandom_range(20, 300)), 5'd16);
      run_random(60, 20);
      finish_phase();

      configure($urandom, 16'($urandom), 5'($urandom_range(1, 16)));
      run_random(50, sb.slots_in_use() + 4);
      finish_phase();

      configure($urandom, 16'($urandom_range(0, 50)), 5'd15);
      run_random(50, 18);
      finish_phase();

      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
